FILE: rtl/core/cse_pkg.sv
package cse_pkg;

	// Stream payload widths (fields packed from bit 0, padded to whole bytes)
	localparam int IN_TDATA_W  = 72;  // coef_index(4), coef_value(32), x_value(32)
	localparam int OUT_TDATA_W = 72;  // poly_value(64), order_index(4)

	localparam int IDX_W   = 4;
	localparam int COEF_W  = 32;
	localparam int VAL_W   = 64;
	localparam int TC_W    = 5;
	localparam int CFG_W   = 5;
	localparam int MUL_A_W = 33;
	localparam int MUL_P_W = MUL_A_W + COEF_W;
	localparam int PROD_W  = 97;

	// Largest number of results one evaluate beat may cause
	localparam int RESULT_CAP = 16;

	// Beat kinds on s_axis_tuser
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_EVAL = 1'b1;

	// Register indexes
	localparam logic REG_TERM_COUNT  = 1'b0;
	localparam logic REG_OUTPUT_MODE = 1'b1;

	// Sequencer states
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_STEP = 7'b0000010,
		ST_MLO  = 7'b0000100,
		ST_MHI  = 7'b0001000,
		ST_RND  = 7'b0010000,
		ST_ACC  = 7'b0100000,
		ST_EMIT = 7'b1000000
	} state_t;

endpackage

FILE: rtl/core/chebyshev_series_evaluator.sv
// Chebyshev series evaluator, first kind, fixed point.
//
// Input stream (s_axis): tuser selects the beat kind. A load beat writes one
// signed coefficient into the coefficient RAM. An evaluate beat runs T0 = 1,
// T1 = x, T(j+1) = 2x*T(j) - T(j-1) over term_count orders (0 acts as 1,
// capped at NCAP). Output stream (m_axis): sum mode gives one beat (the series
// sum, tlast set); per-order mode gives T0..T(n-1), tlast on the final one.
// tuser flags any saturation to the signed 64-bit range up to that beat.
// Config port: cfg_we writes cfg_data into the register at cfg_index
// (0 term_count, 1 output_mode); write only while the block is idle.
// Datapath: each 64x32 product goes through one 33x32 multiplier in two halves
// (ST_MLO, ST_MHI), then a round/saturate step (ST_RND) and an accumulate step
// (ST_ACC). One evaluate beat is worked at a time; s_axis_tready is high only
// while idle. A result sits in an output register, so a stalled receiver only
// halts the sequencer when the next result is ready.
// Reset clears the sequencer and output valid, term_count to 1 and
// output_mode to 0; the coefficient RAM is not cleared.
module chebyshev_series_evaluator #(
	parameter int MAX_TERMS   = 16,
	parameter int X_FRAC_BITS = 28
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input stream
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [cse_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // coef_index, coef_value, x_value
	input  logic                             s_axis_tuser,  // action
	// output stream
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [cse_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // poly_value, order_index
	output logic                             m_axis_tlast,
	output logic                             m_axis_tuser,  // saturated
	// config
	input  logic                             cfg_we,
	input  logic                             cfg_index,
	input  logic [cse_pkg::CFG_W-1:0]        cfg_data
);

	import cse_pkg::*;

	localparam int AW   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int NCAP = (MAX_TERMS < RESULT_CAP) ? MAX_TERMS : RESULT_CAP;
	localparam logic signed [PROD_W-1:0] HALF_R = PROD_W'(1) << (X_FRAC_BITS - 2);
	localparam logic signed [PROD_W-1:0] HALF_C = PROD_W'(1) << (X_FRAC_BITS - 1);
	localparam logic signed [VAL_W-1:0]  ONE    = VAL_W'(1) << X_FRAC_BITS;
	localparam logic signed [VAL_W-1:0]  VMAX   = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0]  VMIN   = {1'b1, {(VAL_W-1){1'b0}}};

	// input fields
	logic [IDX_W-1:0]         in_idx;
	logic signed [COEF_W-1:0] in_coef;
	logic signed [COEF_W-1:0] in_x;
	assign in_idx  = s_axis_tdata[3:0];
	assign in_coef = s_axis_tdata[35:4];
	assign in_x    = s_axis_tdata[67:36];

	// control
	state_t          state_q;
	logic [TC_W-1:0] term_count_q;
	logic            output_mode_q;
	logic [TC_W-1:0] n_q;
	logic [TC_W-1:0] j_q;
	logic            phase_q;      // 0: recurrence product, 1: coefficient product
	logic            out_valid_q;

	// datapath
	logic signed [COEF_W-1:0] x_q;
	logic signed [VAL_W-1:0]  tprev_q, tcur_q, acc_q, r_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                     sat_q;
	logic [VAL_W-1:0]         out_val_q;
	logic [IDX_W-1:0]         out_ord_q;
	logic                     out_last_q, out_sat_q;

	logic in_acc, out_free, term_last, advance;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign out_free      = !out_valid_q | m_axis_tready;
	assign term_last     = ((j_q + TC_W'(1)) == n_q);
	assign advance = ((state_q == ST_ACC) & phase_q & !term_last) |
		((state_q == ST_EMIT) & out_free & output_mode_q & !term_last);

	// coefficient RAM
	logic              ram_we;
	logic [COEF_W-1:0] coef_rd;
	assign ram_we = in_acc & (s_axis_tuser == ACT_LOAD) & (32'(in_idx) < MAX_TERMS);

	cse_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TERMS)) u_coef_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(in_idx)),
		.wdata (in_coef),
		.re    (state_q == ST_STEP),
		.raddr (AW'(j_q)),
		.rdata (coef_rd)
	);

	// shared 33x32 multiplier, low half then high half of tcur
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [COEF_W-1:0]  mul_b;
	logic signed [MUL_P_W-1:0] mul_p;
	assign mul_a = (state_q == ST_MHI) ? $signed({tcur_q[63], tcur_q[63:32]})
		: $signed({1'b0, tcur_q[31:0]});
	assign mul_b = phase_q ? $signed(coef_rd) : x_q;
	assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

	// round half up, shift, saturate
	logic signed [PROD_W-1:0] rsum, rsh;
	logic                     rovf;
	logic signed [VAL_W-1:0]  rval;
	assign rsum = prod_q + (phase_q ? HALF_C : HALF_R);
	assign rsh  = phase_q ? (rsum >>> X_FRAC_BITS) : (rsum >>> (X_FRAC_BITS - 1));
	assign rovf = (rsh[PROD_W-1:VAL_W-1] != {(PROD_W-VAL_W+1){rsh[VAL_W-1]}});
	assign rval = rovf ? (rsh[PROD_W-1] ? VMIN : VMAX) : rsh[VAL_W-1:0];

	// saturating add (sum mode) or subtract (recurrence)
	logic signed [VAL_W:0]   aw;
	logic                    aovf;
	logic signed [VAL_W-1:0] aval;
	assign aw   = phase_q ? ({acc_q[63], acc_q} + {r_q[63], r_q})
		: ({r_q[63], r_q} - {tprev_q[63], tprev_q});
	assign aovf = (aw[VAL_W] != aw[VAL_W-1]);
	assign aval = aovf ? (aw[VAL_W] ? VMIN : VMAX) : aw[VAL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			term_count_q  <= TC_W'(1);
			output_mode_q <= 1'b0;
			n_q           <= TC_W'(1);
			j_q           <= '0;
			phase_q       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TERM_COUNT:  term_count_q  <= cfg_data[TC_W-1:0];
					REG_OUTPUT_MODE: output_mode_q <= cfg_data[0];
					default: ;
				endcase
			end
			// a new result replaces the one leaving in the same cycle
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && s_axis_tuser == ACT_EVAL) begin
						j_q <= '0;
						if (term_count_q == '0) begin
							n_q <= TC_W'(1);
						end else if (32'(term_count_q) > NCAP) begin
							n_q <= TC_W'(NCAP);
						end else begin
							n_q <= term_count_q;
						end
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (output_mode_q) begin
						state_q <= ST_EMIT;
					end else begin
						phase_q <= 1'b1;
						state_q <= ST_MLO;
					end
				end
				ST_MLO: state_q <= ST_MHI;
				ST_MHI: state_q <= ST_RND;
				ST_RND: state_q <= ST_ACC;
				ST_ACC: begin
					if (!phase_q) begin
						state_q <= ST_STEP;
					end else if (term_last) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (!output_mode_q || term_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (advance) begin
				j_q <= j_q + TC_W'(1);
				if (j_q == '0) begin
					state_q <= ST_STEP;
				end else begin
					phase_q <= 1'b0;
					state_q <= ST_MLO;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q     <= in_x;
				tprev_q <= '0;
				tcur_q  <= ONE;
				acc_q   <= '0;
				sat_q   <= 1'b0;
			end
			ST_MLO: prod_q <= PROD_W'(mul_p);
			ST_MHI: prod_q <= prod_q + {mul_p, 32'd0};
			ST_RND: begin
				r_q   <= rval;
				sat_q <= sat_q | rovf;
			end
			ST_ACC: begin
				sat_q <= sat_q | aovf;
				if (phase_q) begin
					acc_q <= aval;
				end else begin
					tprev_q <= tcur_q;
					tcur_q  <= aval;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_val_q  <= output_mode_q ? tcur_q : acc_q;
					out_ord_q  <= output_mode_q ? j_q[IDX_W-1:0] : '0;
					out_last_q <= !output_mode_q | term_last;
					out_sat_q  <= sat_q;
				end
			end
			default: ;
		endcase
		// order 1 takes x directly
		if (advance && j_q == '0) begin
			tprev_q <= tcur_q;
			tcur_q  <= VAL_W'(x_q);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_ord_q, out_val_q};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_sat_q;

endmodule

FILE: rtl/core/cse_ram.sv
module cse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
